@@ src/mecanum_wheel_odometry_macros.svh @@
// assertion macros for the mecanum odometry block
// used by the top level only
`ifndef MECANUM_WHEEL_ODOMETRY_MACROS_SVH
`define MECANUM_WHEEL_ODOMETRY_MACROS_SVH

// implication checked on every clock edge outside reset
`define MWO_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every clock edge, reset included
`define MWO_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ src/mwo_pkg.sv @@
// shared types, constants and tables for the mecanum odometry block
// no dependencies
package mwo_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanLen = 24;
  localparam int StepW = 5;

  localparam logic [1:0] RegSpeedScale = 2'd0;
  localparam logic [1:0] RegInvHalfSum = 2'd1;
  localparam logic [1:0] RegStepTime = 2'd2;

  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic signed [31:0] RadToTurn = 32'sd683565276;

  localparam logic signed [39:0] PosMax = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] PosMin = 40'sh8000000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_VEL,
    ST_YAW,
    ST_CORDIC,
    ST_GAIN,
    ST_STEP,
    ST_DTH,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic mul_start;
  } mul_ctrl_t;

  function automatic logic signed [32:0] atan_entry(input logic [StepW-1:0] idx);
    logic signed [32:0] r;
    unique case (idx)
      5'd0: r = 33'sd536870912;
      5'd1: r = 33'sd316933406;
      5'd2: r = 33'sd167458907;
      5'd3: r = 33'sd85004756;
      5'd4: r = 33'sd42667331;
      5'd5: r = 33'sd21354465;
      5'd6: r = 33'sd10679838;
      5'd7: r = 33'sd5340245;
      5'd8: r = 33'sd2670163;
      5'd9: r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/mwo_serial_mul.sv @@
// bit-serial signed by unsigned multiplier, two multiplier bits per cycle
// uses mwo_pkg
module mwo_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mwo_pkg::mul_ctrl_t  ctrl_i,
  input  logic signed [47:0]  a_i,
  input  logic [31:0]         b_i,
  output logic                done_o,
  output logic signed [79:0]  p_o
);

  logic signed [79:0] acc_q, acc_d;
  logic [31:0] b_q, b_d;
  logic signed [79:0] a_q, a_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic signed [79:0] pp;

  always_comb begin
    acc_d = acc_q;
    b_d = b_q;
    a_d = a_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    pp = '0;
    if (ctrl_i.mul_start) begin
      acc_d = '0;
      a_d = 80'(a_i);
      b_d = b_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      unique case (b_q[1:0])
        2'd0: pp = '0;
        2'd1: pp = a_q;
        2'd2: pp = a_q <<< 1;
        default: pp = a_q + (a_q <<< 1);
      endcase
      acc_d = acc_q + pp;
      a_d = a_q <<< 2;
      b_d = b_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = !busy_q && !ctrl_i.mul_start;
  assign p_o = acc_q;

endmodule

@@ src/mecanum_wheel_odometry.sv @@
// mecanum odometry top level: kinematics, cordic rotation and integration
// uses mwo_pkg, mwo_serial_mul and mecanum_wheel_odometry_macros.svh
//
// Slave channel s_axis carries one wheel frame per transfer: four direction
// bits and four 8-bit pulse counts. Master channel m_axis returns the pose
// after the update (x, y, heading) and the frame's body velocities.
// Configuration writes (speed scale, reciprocal half sum, step time) go
// through cfg_we_i / cfg_idx_i / cfg_data_i and must land while idle.
// One frame at a time: between input transfer and m_axis_tvalid lie ten
// passes of the 2-bit-per-cycle shared multiplier, 16 CORDIC iterations
// at one per cycle and the velocity, accumulate and output steps. With a
// ready receiver the next frame is taken in the cycle after the result is
// loaded. Reset clears pose to zero and loads default register values;
// no result is pending. While the receiver stalls, the result holds in its
// register; the next frame is still taken and computed, then waits in the
// last step until the result register is free.
`include "mecanum_wheel_odometry_macros.svh"
module mecanum_wheel_odometry (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // front_left_sign, front_left_count, front_right_sign, front_right_count,
  // rear_left_sign, rear_left_count, rear_right_sign, rear_right_count
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, heading, vel_x, vel_y, yaw_rate
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);

  mwo_pkg::state_e state_q, state_d;
  logic [23:0] scale_q, inv_q;
  logic [15:0] step_q;
  logic signed [39:0] x_q, y_q;
  logic [15:0] yaw_q;
  logic signed [31:0] vx_q, vy_q, vth_q;
  logic signed [47:0] sum_q [3];
  logic [1:0] mcnt_q, mcnt_d;
  logic signed [47:0] cx_q, cy_q;
  logic signed [32:0] z_q;
  logic [mwo_pkg::StepW-1:0] it_q;
  logic signed [47:0] rx_q, ry_q, p_q;
  logic [191:0] res_q;
  logic out_v_q;
  logic out_fire;

  mwo_pkg::mul_ctrl_t mctl;
  logic mdone;
  logic signed [79:0] mp;
  logic signed [47:0] ma;
  logic [31:0] mb;
  logic mul_fire;

  logic signed [9:0] c [4];
  logic signed [11:0] ksum [3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c[k] = s_axis_tdata[9*k] ? 10'(s_axis_tdata[9*k+1 +: 8])
                               : -10'(s_axis_tdata[9*k+1 +: 8]);
    end
    ksum[0] = 12'(c[0]) + 12'(c[1]) + 12'(c[2]) + 12'(c[3]);
    ksum[1] = 12'(c[0]) - 12'(c[1]) + 12'(c[2]) - 12'(c[3]);
    ksum[2] = 12'(c[0]) - 12'(c[1]) - 12'(c[2]) + 12'(c[3]);
  end

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [79:0] rshr(input logic signed [79:0] v, input int n);
    logic signed [79:0] t;
    t = v + (80'sd1 <<< (n - 1));
    return t >>> n;
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      mwo_pkg::ST_MUL: begin
        ma = sum_q[mcnt_q];
        mb = 32'(scale_q);
      end
      mwo_pkg::ST_YAW: begin
        ma = sum_q[2];
        mb = 32'(inv_q);
      end
      mwo_pkg::ST_GAIN: begin
        ma = (mcnt_q == 2'd0) ? cx_q : cy_q;
        mb = 32'(mwo_pkg::GainQ30);
      end
      mwo_pkg::ST_STEP: begin
        ma = (mcnt_q == 2'd0) ? rx_q : ((mcnt_q == 2'd1) ? ry_q : 48'(vth_q));
        mb = 32'(step_q);
      end
      mwo_pkg::ST_DTH: begin
        ma = p_q;
        mb = 32'(mwo_pkg::RadToTurn);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  mwo_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctl),
    .a_i    (ma),
    .b_i    (mb),
    .done_o (mdone),
    .p_o    (mp)
  );

  logic started_q, started_d;
  assign mctl.mul_start = mul_fire;
  assign mul_fire = !started_q && (state_q == mwo_pkg::ST_MUL || state_q == mwo_pkg::ST_YAW ||
                    state_q == mwo_pkg::ST_GAIN || state_q == mwo_pkg::ST_STEP ||
                    state_q == mwo_pkg::ST_DTH);
  logic mul_ok;
  assign mul_ok = started_q && mdone;

  assign s_axis_tready = (state_q == mwo_pkg::ST_IDLE);
  assign out_fire = (state_q == mwo_pkg::ST_OUT) && (!out_v_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    mcnt_d = mcnt_q;
    unique case (state_q)
      mwo_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        state_d = mwo_pkg::ST_MUL;
        mcnt_d = '0;
      end
      mwo_pkg::ST_MUL: if (mul_ok) begin
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd2) state_d = mwo_pkg::ST_VEL;
      end
      mwo_pkg::ST_VEL: state_d = mwo_pkg::ST_YAW;
      mwo_pkg::ST_YAW: if (mul_ok) state_d = mwo_pkg::ST_CORDIC;
      mwo_pkg::ST_CORDIC: if (32'(it_q) == mwo_pkg::CordicSteps - 1) begin
        state_d = mwo_pkg::ST_GAIN;
        mcnt_d = '0;
      end
      mwo_pkg::ST_GAIN: if (mul_ok) begin
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd1) begin
          state_d = mwo_pkg::ST_STEP;
          mcnt_d = '0;
        end
      end
      mwo_pkg::ST_STEP: if (mul_ok) begin
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd2) state_d = mwo_pkg::ST_DTH;
      end
      mwo_pkg::ST_DTH: if (mul_ok) state_d = mwo_pkg::ST_ACC;
      mwo_pkg::ST_ACC: state_d = mwo_pkg::ST_OUT;
      mwo_pkg::ST_OUT: if (out_fire) state_d = mwo_pkg::ST_IDLE;
      default: state_d = mwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    started_d = started_q;
    if (mul_fire) started_d = 1'b1;
    else if (mul_ok) started_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwo_pkg::ST_IDLE;
      mcnt_q <= '0;
      started_q <= 1'b0;
      scale_q <= 24'd65536;
      inv_q <= 24'd65536;
      step_q <= 16'd3277;
      x_q <= '0;
      y_q <= '0;
      yaw_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mcnt_q <= mcnt_d;
      started_q <= started_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mwo_pkg::RegSpeedScale: scale_q <= cfg_data_i;
          mwo_pkg::RegInvHalfSum: inv_q <= cfg_data_i;
          mwo_pkg::RegStepTime: step_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == mwo_pkg::ST_ACC) begin
        logic signed [41:0] nx, ny;
        nx = 42'(x_q) + 42'(rx_q);
        ny = 42'(y_q) + 42'(ry_q);
        x_q <= (nx > 42'(mwo_pkg::PosMax)) ? mwo_pkg::PosMax :
               (nx < 42'(mwo_pkg::PosMin)) ? mwo_pkg::PosMin : nx[39:0];
        y_q <= (ny > 42'(mwo_pkg::PosMax)) ? mwo_pkg::PosMax :
               (ny < 42'(mwo_pkg::PosMin)) ? mwo_pkg::PosMin : ny[39:0];
        yaw_q <= yaw_q + p_q[15:0];
      end
      if (out_fire) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int k = 0; k < 3; k++) sum_q[k] <= 48'(ksum[k]);
    end
    unique case (state_q)
      mwo_pkg::ST_MUL: if (mul_ok) sum_q[mcnt_q] <= mp[47:0];
      mwo_pkg::ST_VEL: begin
        vx_q <= sat32(rshr(80'(sum_q[0]), 2));
        vy_q <= sat32(rshr(80'(sum_q[1]), 2));
      end
      mwo_pkg::ST_YAW: if (mul_ok) begin
        logic signed [31:0] th;
        logic [31:0] ang;
        th = sat32(rshr(mp, 18));
        vth_q <= th;
        ang = {yaw_q, 16'd0};
        if (ang[31] != ang[30]) begin
          cx_q <= -48'(vx_q);
          cy_q <= -48'(vy_q);
          ang = ang - 32'h80000000;
        end else begin
          cx_q <= 48'(vx_q);
          cy_q <= 48'(vy_q);
        end
        z_q <= 33'(signed'(ang));
        it_q <= '0;
      end
      mwo_pkg::ST_CORDIC: begin
        logic signed [47:0] sx, sy;
        sx = cx_q >>> it_q;
        sy = cy_q >>> it_q;
        if (z_q >= 0) begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          z_q <= z_q - mwo_pkg::atan_entry(it_q);
        end else begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          z_q <= z_q + mwo_pkg::atan_entry(it_q);
        end
        it_q <= it_q + 5'd1;
      end
      mwo_pkg::ST_GAIN: if (mul_ok) begin
        if (mcnt_q == 2'd0) rx_q <= 48'(rshr(mp, 30));
        else ry_q <= 48'(rshr(mp, 30));
      end
      mwo_pkg::ST_STEP: if (mul_ok) begin
        if (mcnt_q == 2'd0) rx_q <= 48'(rshr(mp, 16));
        else if (mcnt_q == 2'd1) ry_q <= 48'(rshr(mp, 16));
        else p_q <= 48'(rshr(mp, 16));
      end
      mwo_pkg::ST_DTH: if (mul_ok) p_q <= 48'(rshr(mp, 32));
      mwo_pkg::ST_OUT: if (out_fire) res_q <= {vth_q, vy_q, vx_q, yaw_q, y_q, x_q};
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = res_q;

  `MWO_ASSERT(a_busy_not_ready, clk_i, rst_ni,
    (state_q != mwo_pkg::ST_IDLE) |-> !s_axis_tready)
  `MWO_ASSERT(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(res_q)))
  `MWO_ASSERT(a_pose_stable, clk_i, rst_ni,
    (state_q == mwo_pkg::ST_IDLE) |=> ($stable(x_q) && $stable(yaw_q)))
  `MWO_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |-> !m_axis_tvalid)

endmodule
